// File: hdl/detection_box_decode_filter_defines.svh
// Assertion macros used by the detection box decode filter checker.
`ifndef DETECTION_BOX_DECODE_FILTER_DEFINES_SVH
`define DETECTION_BOX_DECODE_FILTER_DEFINES_SVH

// Clocked assertion, switched off while reset is asserted.
`define DBDF_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked assertion that also holds while reset is asserted.
`define DBDF_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/dbdf_pkg.sv
// Package: widths, codes, config and control types, helper functions for the box filter.
package dbdf_pkg;

	localparam int FRACTION_BITS = 4;
	localparam int SCALE_SHIFT   = FRACTION_BITS + 1;

	localparam int COORD_W = 18;
	localparam int SCORE_W = 16;
	localparam int NET_W   = 13;
	localparam int GEOM_W  = 17;
	localparam int CLS_W   = 2;

	localparam int LIM_W = NET_W + SCALE_SHIFT;
	localparam int RAW_W = ((COORD_W + 2) > (LIM_W + 1)) ? (COORD_W + 2) : (LIM_W + 1);

	localparam int NUM_STAGES = 4;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam int IN_DATA_W   = 4 * COORD_W + 3 * SCORE_W;
	localparam int IN_TDATA_W  = ((IN_DATA_W + 7) / 8) * 8;
	localparam int OUT_DATA_W  = 4 * GEOM_W + SCORE_W;
	localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;
	localparam int OUT_USER_W  = 1 + CLS_W;

	localparam int GEOM_MAX = (1 << GEOM_W) - 1;

	localparam logic [NET_W-1:0]   NET_RESET = NET_W'(640);
	localparam logic [SCORE_W-1:0] THR_RESET = SCORE_W'(16384);
	localparam logic [LIM_W-1:0]   ONE_PIXEL = LIM_W'(1 << SCALE_SHIFT);

	typedef enum logic [CLS_W-1:0] {
		CLS_FIRE  = 2'd0,
		CLS_OTHER = 2'd1,
		CLS_SMOKE = 2'd2
	} cls_t;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_NET_WIDTH  = 3'd0,
		REG_NET_HEIGHT = 3'd1,
		REG_THR_FIRE   = 3'd2,
		REG_THR_OTHER  = 3'd3,
		REG_THR_SMOKE  = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [NET_W-1:0]   net_width;
		logic [NET_W-1:0]   net_height;
		logic [SCORE_W-1:0] thr_fire;
		logic [SCORE_W-1:0] thr_other;
		logic [SCORE_W-1:0] thr_smoke;
	} cfg_t;

	typedef struct packed {
		logic [NUM_STAGES-1:0] en;
	} pipe_ctl_t;

	// clamp a signed value to [0, lim]
	function automatic logic [LIM_W-1:0] clamp_lim(input logic signed [RAW_W-1:0] v,
			input logic [LIM_W-1:0] lim);
		logic [RAW_W-2:0] lim_x;
		lim_x = (RAW_W-1)'(lim);
		if (v[RAW_W-1]) begin
			clamp_lim = '0;
		end else if (v[RAW_W-2:0] > lim_x) begin
			clamp_lim = lim;
		end else begin
			clamp_lim = v[LIM_W-1:0];
		end
	endfunction

	// drop the extra fraction bit, round half up, saturate
	function automatic logic [GEOM_W-1:0] to_geom(input logic [LIM_W-1:0] v);
		logic [LIM_W:0]   sum;
		logic [LIM_W-1:0] half;
		sum  = {1'b0, v} + (LIM_W+1)'(1);
		half = sum[LIM_W:1];
		if ((LIM_W+GEOM_W)'(half) > (LIM_W+GEOM_W)'(GEOM_MAX)) begin
			to_geom = GEOM_W'(GEOM_MAX);
		end else begin
			to_geom = GEOM_W'(half);
		end
	endfunction

endpackage

// File: hdl/dbdf_ctrl.sv
// Pipeline valid/ready control: per-stage valid bits and load enables.
module dbdf_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_valid,
	output logic                  s_ready,
	output logic                  m_valid,
	input  logic                  m_ready,
	output dbdf_pkg::pipe_ctl_t   ctl
);

	logic [dbdf_pkg::NUM_STAGES-1:0] vld_q;
	logic [dbdf_pkg::NUM_STAGES-1:0] rdy;
	logic [dbdf_pkg::NUM_STAGES-1:0] vin;

	always_comb begin
		rdy[dbdf_pkg::NUM_STAGES-1] = !vld_q[dbdf_pkg::NUM_STAGES-1] || m_ready;
		for (int k = dbdf_pkg::NUM_STAGES - 2; k >= 0; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
		vin[0] = s_valid;
		for (int k = 1; k < dbdf_pkg::NUM_STAGES; k++) begin
			vin[k] = vld_q[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < dbdf_pkg::NUM_STAGES; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vin[k];
				end
			end
		end
	end

	assign ctl.en  = rdy;
	assign s_ready = rdy[0];
	assign m_valid = vld_q[dbdf_pkg::NUM_STAGES-1];

endmodule

// File: hdl/dbdf_cls.sv
// Class pick and threshold test, carried down to the last pipeline stage.
module dbdf_cls (
	input  logic                             clk,
	input  dbdf_pkg::pipe_ctl_t              ctl,
	input  dbdf_pkg::cfg_t                   cfg,
	input  logic [dbdf_pkg::SCORE_W-1:0]     score_fire,
	input  logic [dbdf_pkg::SCORE_W-1:0]     score_other,
	input  logic [dbdf_pkg::SCORE_W-1:0]     score_smoke,
	input  logic                             last_in,
	output dbdf_pkg::cls_t                   cls_s4,
	output logic [dbdf_pkg::SCORE_W-1:0]     score_s4,
	output logic                             pass_s4,
	output logic                             last_s4
);

	dbdf_pkg::cls_t               cls_c;
	logic [dbdf_pkg::SCORE_W-1:0] best_c;
	logic [dbdf_pkg::SCORE_W-1:0] thr_c;

	dbdf_pkg::cls_t               cls_s1, cls_s2, cls_s3;
	logic [dbdf_pkg::SCORE_W-1:0] score_s1, score_s2, score_s3;
	logic                         pass_s1, pass_s2, pass_s3;
	logic                         last_s1, last_s2, last_s3;

	// ties keep the lower class
	always_comb begin
		cls_c  = dbdf_pkg::CLS_FIRE;
		best_c = score_fire;
		if (score_other > best_c) begin
			cls_c  = dbdf_pkg::CLS_OTHER;
			best_c = score_other;
		end
		if (score_smoke > best_c) begin
			cls_c  = dbdf_pkg::CLS_SMOKE;
			best_c = score_smoke;
		end
		unique case (cls_c)
			dbdf_pkg::CLS_FIRE:  thr_c = cfg.thr_fire;
			dbdf_pkg::CLS_OTHER: thr_c = cfg.thr_other;
			dbdf_pkg::CLS_SMOKE: thr_c = cfg.thr_smoke;
			default:             thr_c = cfg.thr_smoke;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.en[0]) begin
			cls_s1   <= cls_c;
			score_s1 <= best_c;
			pass_s1  <= best_c >= thr_c;
			last_s1  <= last_in;
		end
		if (ctl.en[1]) begin
			cls_s2   <= cls_s1;
			score_s2 <= score_s1;
			pass_s2  <= pass_s1;
			last_s2  <= last_s1;
		end
		if (ctl.en[2]) begin
			cls_s3   <= cls_s2;
			score_s3 <= score_s2;
			pass_s3  <= pass_s2;
			last_s3  <= last_s2;
		end
		if (ctl.en[3]) begin
			cls_s4   <= cls_s3;
			score_s4 <= score_s3;
			pass_s4  <= pass_s3;
			last_s4  <= last_s3;
		end
	end

endmodule

// File: hdl/dbdf_geom.sv
// Box geometry: raw corners, corner clamp, size clamp and check, output rounding.
module dbdf_geom (
	input  logic                                 clk,
	input  dbdf_pkg::pipe_ctl_t                  ctl,
	input  dbdf_pkg::cfg_t                       cfg,
	input  logic signed [dbdf_pkg::COORD_W-1:0]  center_x,
	input  logic signed [dbdf_pkg::COORD_W-1:0]  center_y,
	input  logic signed [dbdf_pkg::COORD_W-1:0]  box_w,
	input  logic signed [dbdf_pkg::COORD_W-1:0]  box_h,
	output logic [dbdf_pkg::GEOM_W-1:0]          left_s4,
	output logic [dbdf_pkg::GEOM_W-1:0]          top_s4,
	output logic [dbdf_pkg::GEOM_W-1:0]          width_s4,
	output logic [dbdf_pkg::GEOM_W-1:0]          height_s4,
	output logic                                 size_ok_s4
);

	logic [dbdf_pkg::LIM_W-1:0] lim_x, lim_y;

	logic signed [dbdf_pkg::COORD_W:0]  two_x, two_y;

	logic signed [dbdf_pkg::RAW_W-1:0] x1_s1, x2_s1, y1_s1, y2_s1;
	logic [dbdf_pkg::LIM_W-1:0]        x1_s2, x2_s2, y1_s2, y2_s2;
	logic signed [dbdf_pkg::LIM_W:0]   dx, dy;
	logic [dbdf_pkg::LIM_W-1:0]        bw_c, bh_c;
	logic [dbdf_pkg::LIM_W-1:0]        x1_s3, y1_s3, bw_s3, bh_s3;
	logic                              size_ok_s3;

	assign lim_x = {cfg.net_width,  {dbdf_pkg::SCALE_SHIFT{1'b0}}};
	assign lim_y = {cfg.net_height, {dbdf_pkg::SCALE_SHIFT{1'b0}}};

	assign two_x = {center_x, 1'b0};
	assign two_y = {center_y, 1'b0};

	// corners at one extra fraction bit: 2c -/+ size
	always_ff @(posedge clk) begin
		if (ctl.en[0]) begin
			x1_s1 <= dbdf_pkg::RAW_W'(two_x) - dbdf_pkg::RAW_W'(box_w);
			x2_s1 <= dbdf_pkg::RAW_W'(two_x) + dbdf_pkg::RAW_W'(box_w);
			y1_s1 <= dbdf_pkg::RAW_W'(two_y) - dbdf_pkg::RAW_W'(box_h);
			y2_s1 <= dbdf_pkg::RAW_W'(two_y) + dbdf_pkg::RAW_W'(box_h);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[1]) begin
			x1_s2 <= dbdf_pkg::clamp_lim(x1_s1, lim_x);
			x2_s2 <= dbdf_pkg::clamp_lim(x2_s1, lim_x);
			y1_s2 <= dbdf_pkg::clamp_lim(y1_s1, lim_y);
			y2_s2 <= dbdf_pkg::clamp_lim(y2_s1, lim_y);
		end
	end

	assign dx   = $signed({1'b0, x2_s2}) - $signed({1'b0, x1_s2});
	assign dy   = $signed({1'b0, y2_s2}) - $signed({1'b0, y1_s2});
	assign bw_c = dbdf_pkg::clamp_lim(dbdf_pkg::RAW_W'(dx), lim_x);
	assign bh_c = dbdf_pkg::clamp_lim(dbdf_pkg::RAW_W'(dy), lim_y);

	always_ff @(posedge clk) begin
		if (ctl.en[2]) begin
			x1_s3      <= x1_s2;
			y1_s3      <= y1_s2;
			bw_s3      <= bw_c;
			bh_s3      <= bh_c;
			size_ok_s3 <= (bw_c >= dbdf_pkg::ONE_PIXEL) && (bh_c >= dbdf_pkg::ONE_PIXEL);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[3]) begin
			left_s4    <= dbdf_pkg::to_geom(x1_s3);
			top_s4     <= dbdf_pkg::to_geom(y1_s3);
			width_s4   <= dbdf_pkg::to_geom(bw_s3);
			height_s4  <= dbdf_pkg::to_geom(bh_s3);
			size_ok_s4 <= size_ok_s3;
		end
	end

endmodule

// File: hdl/detection_box_decode_filter.sv
// Top level: detection box decode and filter, config registers and stream ports.
// One candidate box is taken per clock while the input side is ready, and one result
// leaves per box, in order, after passing through the four register stages (class
// pick and raw corners, corner clamp, size clamp and check, rounding). Each stage
// loads whenever it is empty or the stage after it moves, so a stall at the output
// fills the pipeline before the input side sees tready fall. Config writes are meant
// for idle periods only.
module detection_box_decode_filter (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// center_x, center_y, box_w, box_h, score_fire, score_other, score_smoke
	input  logic [dbdf_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// frame_last_in
	input  logic                                s_axis_tlast,

	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// left, top, out_width, out_height, confidence, zero pad
	output logic [dbdf_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	// keep, class_id
	output logic [dbdf_pkg::OUT_USER_W-1:0]     m_axis_tuser,
	// frame_last_out
	output logic                                m_axis_tlast,

	input  logic                                cfg_wr_en,
	input  logic [dbdf_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [dbdf_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	localparam int CW = dbdf_pkg::COORD_W;
	localparam int SW = dbdf_pkg::SCORE_W;

	dbdf_pkg::cfg_t      cfg_q;
	dbdf_pkg::pipe_ctl_t ctl;

	dbdf_pkg::cls_t               cls_s4;
	logic [dbdf_pkg::SCORE_W-1:0] score_s4;
	logic                         pass_s4, last_s4;
	logic [dbdf_pkg::GEOM_W-1:0]  left_s4, top_s4, width_s4, height_s4;
	logic                         size_ok_s4;
	logic                         keep;
	logic [4*dbdf_pkg::GEOM_W-1:0] geom;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.net_width  <= dbdf_pkg::NET_RESET;
			cfg_q.net_height <= dbdf_pkg::NET_RESET;
			cfg_q.thr_fire   <= dbdf_pkg::THR_RESET;
			cfg_q.thr_other  <= dbdf_pkg::THR_RESET;
			cfg_q.thr_smoke  <= dbdf_pkg::THR_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				dbdf_pkg::REG_NET_WIDTH:  cfg_q.net_width  <= cfg_wdata[dbdf_pkg::NET_W-1:0];
				dbdf_pkg::REG_NET_HEIGHT: cfg_q.net_height <= cfg_wdata[dbdf_pkg::NET_W-1:0];
				dbdf_pkg::REG_THR_FIRE:   cfg_q.thr_fire   <= cfg_wdata[SW-1:0];
				dbdf_pkg::REG_THR_OTHER:  cfg_q.thr_other  <= cfg_wdata[SW-1:0];
				dbdf_pkg::REG_THR_SMOKE:  cfg_q.thr_smoke  <= cfg_wdata[SW-1:0];
				default: ;
			endcase
		end
	end

	dbdf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_ready (s_axis_tready),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.ctl     (ctl)
	);

	dbdf_cls u_cls (
		.clk         (clk),
		.ctl         (ctl),
		.cfg         (cfg_q),
		.score_fire  (s_axis_tdata[4*CW +: SW]),
		.score_other (s_axis_tdata[4*CW+SW +: SW]),
		.score_smoke (s_axis_tdata[4*CW+2*SW +: SW]),
		.last_in     (s_axis_tlast),
		.cls_s4      (cls_s4),
		.score_s4    (score_s4),
		.pass_s4     (pass_s4),
		.last_s4     (last_s4)
	);

	dbdf_geom u_geom (
		.clk        (clk),
		.ctl        (ctl),
		.cfg        (cfg_q),
		.center_x   ($signed(s_axis_tdata[0 +: CW])),
		.center_y   ($signed(s_axis_tdata[CW +: CW])),
		.box_w      ($signed(s_axis_tdata[2*CW +: CW])),
		.box_h      ($signed(s_axis_tdata[3*CW +: CW])),
		.left_s4    (left_s4),
		.top_s4     (top_s4),
		.width_s4   (width_s4),
		.height_s4  (height_s4),
		.size_ok_s4 (size_ok_s4)
	);

	assign keep = pass_s4 && size_ok_s4;
	assign geom = keep ? {height_s4, width_s4, top_s4, left_s4} : '0;

	assign m_axis_tdata = {{(dbdf_pkg::OUT_TDATA_W-dbdf_pkg::OUT_DATA_W){1'b0}}, score_s4, geom};
	assign m_axis_tuser = {cls_s4, keep};
	assign m_axis_tlast = last_s4;

endmodule

// File: hdl/dbdf_checker.sv
// Port-level checker for the box filter, bound to the top level.
`include "detection_box_decode_filter_defines.svh"

module dbdf_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	input  logic                                s_axis_tready,
	input  logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	input  logic [dbdf_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	input  logic [dbdf_pkg::OUT_USER_W-1:0]     m_axis_tuser
);

	`DBDF_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

	`DBDF_ASSERT(a_drop_zero, m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[4*dbdf_pkg::GEOM_W-1:0] == '0, "dropped box carries geometry")

	`DBDF_ASSERT(a_keep_size, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[3*dbdf_pkg::GEOM_W-1:2*dbdf_pkg::GEOM_W] >= dbdf_pkg::GEOM_W'(1 << dbdf_pkg::FRACTION_BITS) && m_axis_tdata[4*dbdf_pkg::GEOM_W-1:3*dbdf_pkg::GEOM_W] >= dbdf_pkg::GEOM_W'(1 << dbdf_pkg::FRACTION_BITS), "kept box below one pixel")

	`DBDF_ASSERT(a_empty_ready, !m_axis_tvalid |-> s_axis_tready, "input stalled with empty output")

	`DBDF_ASSERT_ALWAYS(a_rst_idle, !arst_n |-> !m_axis_tvalid, "result valid during reset")

endmodule

bind detection_box_decode_filter dbdf_checker u_dbdf_checker (.*);
